FILE: rtl/core/i2c_cfw_pkg.sv
// package: shared types, constants and line decode for the i2c command frame writer
`default_nettype none

package i2c_cfw_pkg;

  // frame layout
  localparam logic [5:0] SegCount   = 6'd62;
  localparam logic [5:0] ByteSegs   = 6'd19;
  localparam logic [5:0] BytesStart = 6'd2;
  localparam logic [5:0] StopFirst  = 6'd59;
  localparam logic [5:0] StopSecond = 6'd60;
  localparam logic [4:0] AckHigh    = 5'd17;

  // input actions
  localparam logic ActTick = 1'b0;
  localparam logic ActSend = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    RegAddress    = 2'd0,
    RegControl    = 2'd1,
    RegHalfPeriod = 2'd2
  } cfg_reg_e;

  // reset values of the configuration registers
  localparam logic [7:0]  AddressReset    = 8'h78;
  localparam logic [7:0]  ControlReset    = 8'h80;
  localparam logic [15:0] HalfPeriodReset = 16'd4;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [7:0]  address_byte;
    logic [7:0]  control_byte;
    logic [15:0] half_period_ticks;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic frame_done;
    logic request_rejected;
  } result_t;

  // line levels {scl, sda} for one frame segment
  function automatic logic [1:0] seg_lines(input logic [5:0] seg,
                                           input logic [7:0] addr,
                                           input logic [7:0] ctrl,
                                           input logic [7:0] cmd);
    logic [5:0] rel;
    logic [5:0] off_w;
    logic [4:0] off;
    logic [1:0] which;
    logic [7:0] data;
    logic [2:0] bitpos;
    logic [1:0] lines;
    rel   = seg - BytesStart;
    which = 2'd0;
    off_w = rel;
    if (rel >= (ByteSegs + ByteSegs)) begin
      which = 2'd2;
      off_w = rel - (ByteSegs + ByteSegs);
    end else if (rel >= ByteSegs) begin
      which = 2'd1;
      off_w = rel - ByteSegs;
    end
    off = off_w[4:0];
    case (which)
      2'd0:    data = addr;
      2'd1:    data = ctrl;
      default: data = cmd;
    endcase
    bitpos = 3'd7 - off[3:1];
    if (seg == 6'd0) begin
      lines = 2'b10;
    end else if (seg == 6'd1) begin
      lines = 2'b00;
    end else if (seg < StopFirst) begin
      if (off < 5'd16) begin
        lines = {off[0], data[bitpos]};
      end else begin
        lines = {(off == AckHigh), 1'b1};
      end
    end else if (seg == StopFirst) begin
      lines = 2'b00;
    end else if (seg == StopSecond) begin
      lines = 2'b10;
    end else begin
      lines = 2'b11;
    end
    return lines;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/i2c_cfw_seq.sv
// segment sequencer: frame state, tick counting and line decode per request
`default_nettype none

module i2c_cfw_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 action_i,
  input  wire logic [7:0]           command_byte_i,
  input  wire i2c_cfw_pkg::cfg_t    cfg_i,
  output i2c_cfw_pkg::result_t      result_o
);

  logic [5:0]  seg_q, seg_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  cmd_q, cmd_d;
  logic        sending_q, sending_d;
  logic [15:0] hp;
  logic [15:0] tick_inc;
  logic [5:0]  seg_inc;
  logic        done;
  logic        rejected;
  logic [1:0]  lines;

  // effective half period, zero acts as one
  assign hp       = (cfg_i.half_period_ticks == 16'd0) ? 16'd1 : cfg_i.half_period_ticks;
  assign tick_inc = tick_q + 16'd1;
  assign seg_inc  = seg_q + 6'd1;

  // next state for the request at the input
  always_comb begin
    seg_d     = seg_q;
    tick_d    = tick_q;
    cmd_d     = cmd_q;
    sending_d = sending_q;
    done      = 1'b0;
    rejected  = 1'b0;
    if (action_i == i2c_cfw_pkg::ActSend) begin
      if (sending_q) begin
        rejected = 1'b1;
      end else begin
        cmd_d     = command_byte_i;
        seg_d     = 6'd0;
        tick_d    = 16'd0;
        sending_d = 1'b1;
      end
    end else if (sending_q) begin
      tick_d = tick_inc;
      if (tick_inc >= hp) begin
        tick_d = 16'd0;
        seg_d  = seg_inc;
        if (seg_inc >= i2c_cfw_pkg::SegCount) begin
          seg_d     = 6'd0;
          sending_d = 1'b0;
          done      = 1'b1;
        end
      end
    end
  end

  // line levels after this request
  always_comb begin
    lines = 2'b11;
    if (sending_d) begin
      lines = i2c_cfw_pkg::seg_lines(seg_d, cfg_i.address_byte, cfg_i.control_byte, cmd_d);
    end
  end

  assign result_o = '{
    scl_level:        lines[1],
    sda_level:        lines[0],
    busy_res:         sending_d,
    frame_done:       done,
    request_rejected: rejected
  };

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q     <= 6'd0;
      tick_q    <= 16'd0;
      cmd_q     <= 8'd0;
      sending_q <= 1'b0;
    end else if (step_i) begin
      seg_q     <= seg_d;
      tick_q    <= tick_d;
      cmd_q     <= cmd_d;
      sending_q <= sending_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/i2c_command_frame_writer_top.sv
// top level: config registers, request handshake and result register
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------
//  in       | in_valid_i / in_ready_o  | action_i, command_byte_i
//  out      | out_valid_o / out_ready_i| scl_level_o, sda_level_o, busy_res_o,
//           |                          | frame_done_o, request_rejected_o
//  cfg      | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
//  One request is taken per cycle while in_ready_o is high; its result shows in the result register the next cycle.
//  The rate is set by the combinational sequencer update (tick add and compare, line decode).
//  The input is ready while the result register is empty or being taken in the same cycle.
//  Reset clears the frame state and result valid and loads the configuration defaults.
`default_nettype none

module i2c_command_frame_writer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  command_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             scl_level_o,
  output logic             sda_level_o,
  output logic             busy_res_o,
  output logic             frame_done_o,
  output logic             request_rejected_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  i2c_cfw_pkg::cfg_t    cfg_q;
  i2c_cfw_pkg::result_t res_d, res_q;
  logic                 out_valid_q;
  logic                 accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_byte      <= i2c_cfw_pkg::AddressReset;
      cfg_q.control_byte      <= i2c_cfw_pkg::ControlReset;
      cfg_q.half_period_ticks <= i2c_cfw_pkg::HalfPeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2c_cfw_pkg::RegAddress:    cfg_q.address_byte      <= cfg_wdata_i[7:0];
        i2c_cfw_pkg::RegControl:    cfg_q.control_byte      <= cfg_wdata_i[7:0];
        i2c_cfw_pkg::RegHalfPeriod: cfg_q.half_period_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  i2c_cfw_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (accept),
    .action_i       (action_i),
    .command_byte_i (command_byte_i),
    .cfg_i          (cfg_q),
    .result_o       (res_d)
  );

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign scl_level_o        = res_q.scl_level;
  assign sda_level_o        = res_q.sda_level;
  assign busy_res_o         = res_q.busy_res;
  assign frame_done_o       = res_q.frame_done;
  assign request_rejected_o = res_q.request_rejected;

  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> !busy_res_o)
    else $error("frame done while still busy");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_rejected_o |-> busy_res_o && !frame_done_o)
    else $error("request rejected while idle");

  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> scl_level_o && sda_level_o)
    else $error("lines not released while idle");

  a_take_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire

FILE: verif/i2c_command_frame_writer_top_tb.sv
// testbench for the i2c command frame writer: line-level prediction and scoreboard check
`timescale 1ns / 1ps

module i2c_command_frame_writer_top_tb;
  import i2c_cfw_pkg::*;

  // register index beyond the register list, writes to it must be dropped
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned RandomItems = 150;

  // line predictor and store of expected line results
  class frame_line_scoreboard;
    logic [7:0]  addr_reg;
    logic [7:0]  ctrl_reg;
    logic [15:0] half_reg;
    logic [5:0]  seg_idx;
    logic [15:0] tick_cnt;
    logic [7:0]  cmd_latch;
    bit          busy;
    result_t     expected_lines_q[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned frames;
    int unsigned rejects;

    function new();
      addr_reg   = AddressReset;
      ctrl_reg   = ControlReset;
      half_reg   = HalfPeriodReset;
      seg_idx    = '0;
      tick_cnt   = '0;
      cmd_latch  = '0;
      busy       = 1'b0;
      mismatches = 0;
      requests   = 0;
      frames     = 0;
      rejects    = 0;
    endfunction

    function void write_cfg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        RegAddress:    addr_reg = data[7:0];
        RegControl:    ctrl_reg = data[7:0];
        RegHalfPeriod: half_reg = data;
        default: ;
      endcase
    endfunction

    // {scl, sda} for a frame segment
    function logic [1:0] segment_levels(logic [5:0] seg);
      int         rel;
      int         which;
      int         off;
      logic [7:0] data;
      if (seg == 6'd0) return 2'b10;
      if (seg == 6'd1) return 2'b00;
      if (seg < StopFirst) begin
        rel   = seg - BytesStart;
        which = rel / ByteSegs;
        off   = rel % ByteSegs;
        data  = (which == 0) ? addr_reg : (which == 1) ? ctrl_reg : cmd_latch;
        if (off < 16) return {off[0], data[7 - off / 2]};
        // ack clock with sda released
        return {(off == AckHigh), 1'b1};
      end
      if (seg == StopFirst) return 2'b00;
      if (seg == StopSecond) return 2'b10;
      return 2'b11;
    endfunction

    // advance the frame state for one accepted request
    function void note_request(logic act, logic [7:0] cmd);
      result_t     want;
      logic [16:0] hp;
      logic [1:0]  lv;
      want = '0;
      if (act == ActSend) begin
        if (busy) begin
          want.request_rejected = 1'b1;
        end else begin
          cmd_latch = cmd;
          seg_idx   = '0;
          tick_cnt  = '0;
          busy      = 1'b1;
        end
      end else if (busy) begin
        // a zero half period counts as one tick
        hp = (half_reg == 16'd0) ? 17'd1 : {1'b0, half_reg};
        tick_cnt = tick_cnt + 16'd1;
        if ({1'b0, tick_cnt} >= hp) begin
          tick_cnt = '0;
          seg_idx  = seg_idx + 6'd1;
          if (seg_idx >= SegCount) begin
            seg_idx = '0;
            busy = 1'b0;
            want.frame_done = 1'b1;
          end
        end
      end
      lv = busy ? segment_levels(seg_idx) : 2'b11;
      want.scl_level = lv[1];
      want.sda_level = lv[0];
      want.busy_res  = busy;
      expected_lines_q.push_back(want);
      requests++;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task field_check(string name, logic got, logic want, int unsigned n);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s got %b want %b", n, name, got, want));
    endtask

    // compare one result with the oldest expectation
    task check_lines(result_t got);
      result_t     want;
      int unsigned n;
      if (expected_lines_q.size() == 0) begin
        report_mismatch($sformatf("result %b with nothing expected", got));
        return;
      end
      want = expected_lines_q.pop_front();
      n = requests - expected_lines_q.size() - 1;
      if (want.frame_done) frames++;
      if (want.request_rejected) rejects++;
      field_check("scl_level", got.scl_level, want.scl_level, n);
      field_check("sda_level", got.sda_level, want.sda_level, n);
      field_check("busy_res", got.busy_res, want.busy_res, n);
      field_check("frame_done", got.frame_done, want.frame_done, n);
      field_check("request_rejected", got.request_rejected, want.request_rejected, n);
    endtask
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        action_i       = 1'b0;
  logic [7:0]  command_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        scl_level_o;
  logic        sda_level_o;
  logic        busy_res_o;
  logic        frame_done_o;
  logic        request_rejected_o;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_idx_i      = 2'd0;
  logic [15:0] cfg_wdata_i    = 16'h0000;

  frame_line_scoreboard sb = new();
  bit          calm = 1'b1;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  int unsigned reg_writes = 0;
  int unsigned settings = 1;
  int unsigned random_start;

  i2c_command_frame_writer_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .command_byte_i     (command_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .scl_level_o        (scl_level_o),
    .sda_level_o        (sda_level_o),
    .busy_res_o         (busy_res_o),
    .frame_done_o       (frame_done_o),
    .request_rejected_o (request_rejected_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: check accepted results, stall at random
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_lines({scl_level_o, sda_level_o, busy_res_o, frame_done_o, request_rejected_o});
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) hold_left = idle_len();
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles", quiet);
      $display("Test completed with failures");
      $finish;
    end
  end

  // one request on the input channel, held until accepted
  task send_request(input logic act, input logic [7:0] cmd);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    command_byte_i <= cmd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(act, cmd);
  endtask

  task tick_request();
    send_request(ActTick, 8'($urandom_range(0, 255)));
  endtask

  // send request, then ticks until the frame ends, with stray sends mixed in
  task run_frame(input logic [7:0] cmd, input int unsigned noise_pct);
    send_request(ActSend, cmd);
    while (sb.busy) begin
      if ($urandom_range(1, 100) <= noise_pct)
        send_request(ActSend, 8'($urandom_range(0, 255)));
      else
        tick_request();
    end
  endtask

  // hold off requests until every expected result is back
  task wait_lines_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_lines_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_cfg(idx, data);
    reg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle ticks, then one frame at the reset settings
    tick_request();
    tick_request();
    run_frame(8'h00, 2);
    tick_request();

    // all-zero address, all-one control, plus a write to the unused index
    wait_lines_drained();
    write_reg(RegAddress, 16'h0000);
    write_reg(RegControl, 16'h00FF);
    write_reg(RegHalfPeriod, 16'd2);
    write_reg(RegUnused, 16'h0001);
    settings++;
    run_frame(8'hFF, 5);
    send_request(ActSend, 8'h3C);
    run_frame(8'hA5, 0);

    // zero half period acts as one
    wait_lines_drained();
    write_reg(RegAddress, 16'hFFFF);
    write_reg(RegControl, 16'hFF00);
    write_reg(RegHalfPeriod, 16'd0);
    settings++;
    run_frame(8'h5A, 5);

    // longest half period, then shortened while the frame is in progress
    wait_lines_drained();
    write_reg(RegHalfPeriod, 16'hFFFF);
    settings++;
    send_request(ActSend, 8'hC3);
    repeat (50) tick_request();
    send_request(ActSend, 8'h11);
    wait_lines_drained();
    write_reg(RegHalfPeriod, 16'd1);
    settings++;
    while (sb.busy) tick_request();

    // random settings and frames
    calm = 1'b0;
    random_start = sb.requests;
    while (sb.requests < random_start + RandomItems) begin
      wait_lines_drained();
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) write_reg(RegAddress, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 1) == 1) write_reg(RegControl, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 1) == 1)
        write_reg(RegHalfPeriod, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3)));
      settings++;
      repeat ($urandom_range(1, 2)) begin
        run_frame(8'($urandom_range(0, 255)), 8);
        repeat ($urandom_range(0, 3)) tick_request();
      end
    end

    // let the last results out
    wait_lines_drained();
    repeat (5) @(posedge clk_i);
    if (sb.expected_lines_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_lines_q.size()));

    $display("covered %0d requests over %0d settings, %0d register writes",
             sb.requests, settings, reg_writes);
    $display("saw %0d complete frames and %0d rejected send requests", sb.frames, sb.rejects);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
